// ----- design/pje_pkg.sv -----
// pje_pkg: widths, constants, codes and sideband types for the planar jog block
// no dependencies; used by every design file of the block
`timescale 1ns / 1ps

package pje_pkg;

  // field widths
  localparam int XW    = 19;   // coordinate
  localparam int CHW   = 17;   // radial change
  localparam int DIRW  = 2;    // rotation direction code
  localparam int CW    = 17;   // signed q16 trig constants

  // datapath widths
  localparam int ROTPW = XW + CW;      // rotation product
  localparam int ROTSW = ROTPW + 2;    // rotation product sum
  localparam int RXW   = XW + 1;       // rotated coordinate, unsaturated
  localparam int SQW   = 2 * RXW;      // square of a rotated coordinate
  localparam int VW    = 56;           // radicand, squared length shifted by 16
  localparam int LW    = VW / 2;       // length in 1/65536 mm
  localparam int NW    = LW + 2;       // numerator, signed
  localparam int PW    = RXW + NW;     // coordinate times numerator
  localparam int DW    = 49;           // rounded dividend magnitude
  localparam int QW    = 23;           // quotient magnitude

  // stream widths
  localparam int IN_DW  = 96;
  localparam int IN_UW  = DIRW;
  localparam int OUT_DW = 80;
  localparam int OUT_UW = 2;

  // pipeline stages in order: rotate mult, rotate sum, square, radicand, sqrt steps,
  // numerator mult, magnitude, divide steps, clamp
  localparam int LAT = 4 + LW + 2 + QW + 1;

  localparam logic signed [CW-1:0] COS_Q16 = 17'sd65523;
  localparam logic signed [CW-1:0] SIN_Q16 = 17'sd1147;

  localparam logic signed [XW-1:0] COORD_MIN = -19'sd262144;
  localparam logic signed [XW-1:0] COORD_MAX = 19'sd262143;

  typedef enum logic [DIRW-1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } rot_dir_t;

  // sideband carried alongside the square root
  typedef struct packed {
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [XW-1:0]  z;
    logic signed [XW-1:0]  e;
    logic signed [CHW-1:0] ch;
    logic signed [RXW-1:0] rx;
    logic signed [RXW-1:0] ry;
    logic                  zero;
  } sb_sqrt_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic signed [XW-1:0] e;
    logic                 zero;
    logic                 neg_x;
    logic                 neg_y;
  } sb_div_t;

endpackage

// ----- design/pje_isqrt.sv -----
// pje_isqrt: pipelined integer square root, one result bit per stage
// depends on pje_pkg for the default width
`timescale 1ns / 1ps

module pje_isqrt #(
  parameter int OW = pje_pkg::LW
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*OW-1:0]   v_in,
  output logic [OW-1:0]     root_out
);

  localparam int RW = OW + 3;

  logic [RW-1:0]   rem_r  [OW];
  logic [OW-1:0]   root_r [OW];
  logic [2*OW-1:0] v_r    [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    localparam int I = OW - 1 - k;
    logic [RW-1:0]   rem_in;
    logic [OW-1:0]   root_in;
    logic [2*OW-1:0] v_k;
    logic [RW-1:0]   rem_t;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   rem_nxt;
    logic [OW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_k     = v_in;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_k     = v_r[k-1];
    end

    always_comb begin
      rem_t = {rem_in[RW-3:0], v_k[2*I+1 -: 2]};
      trial = (RW'(root_in) << 2) | RW'(1);
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_in[OW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_in[OW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        v_r[k]    <= v_k;
      end
    end
  end

  assign root_out = root_r[OW-1];

endmodule

// ----- design/pje_div.sv -----
// pje_div: pipelined restoring divider, one quotient bit per stage
// depends on pje_pkg for default widths
`timescale 1ns / 1ps

module pje_div #(
  parameter int DW = pje_pkg::DW,
  parameter int LW = pje_pkg::LW,
  parameter int QW = pje_pkg::QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num_in,
  input  logic [LW-1:0] den_in,
  output logic [QW-1:0] quo_out
);

  localparam int MW = (DW > LW + QW) ? DW : LW + QW;

  logic [DW-1:0] rem_r [QW];
  logic [LW-1:0] den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [DW-1:0] rem_in;
    logic [LW-1:0] den_k;
    logic [QW-1:0] q_in;
    logic [MW-1:0] sub;
    logic [MW-1:0] remw;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num_in;
      assign den_k  = den_in;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_k  = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      sub  = MW'(den_k) << I;
      remw = MW'(rem_in);
      if (remw >= sub) begin
        rem_nxt = DW'(remw - sub);
        q_nxt   = q_in | (QW'(1) << I);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_k;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign quo_out = q_r[QW-1];

endmodule

// ----- design/planar_jog_rotate_and_extend.sv -----
// planar_jog_rotate_and_extend: rotates (x, y) by a fixed small step and
// rescales its planar length; depends on pje_pkg, pje_isqrt and pje_div
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------------
//   in_     | in  | tdata: pos_x, pos_y, pos_z, pos_e, radial_change; tuser: rot_dir
//   out_    | out | tdata: new_x, new_y, new_z, new_e; tuser: zero_length, saturated
//
// one beat enters per cycle while the output is not stalled; each result passes
// the 28 square root steps and the 23 quotient steps of the dividers
// the whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage, so nothing is lost or repeated
// rst_n is synchronous and clears only the valid bits
`timescale 1ns / 1ps

module planar_jog_rotate_and_extend (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // pos_x[18:0], pos_y[37:19], pos_z[56:38], pos_e[75:57], radial_change[92:76]
  input  logic [pje_pkg::IN_DW-1:0]  in_tdata,
  // rot_dir[1:0]
  input  logic [pje_pkg::IN_UW-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // new_x[18:0], new_y[37:19], new_z[56:38], new_e[75:57]
  output logic [pje_pkg::OUT_DW-1:0] out_tdata,
  // zero_length[0], saturated[1]
  output logic [pje_pkg::OUT_UW-1:0] out_tuser
);

  import pje_pkg::*;

  // rounded division by 65536, ties away from zero
  function automatic logic signed [RXW-1:0] rnd16(input logic signed [ROTSW-1:0] s);
    logic [ROTSW-1:0] mag;
    logic [ROTSW-1:0] q;
    mag = s[ROTSW-1] ? ROTSW'(0) - $unsigned(s) : $unsigned(s);
    q   = (mag + ROTSW'(32768)) >> 16;
    rnd16 = s[ROTSW-1] ? -$signed(RXW'(q)) : $signed(RXW'(q));
  endfunction

  // global advance: all stages move together
  logic adv;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  assign adv       = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // input field split
  logic signed [XW-1:0]  in_x;
  logic signed [XW-1:0]  in_y;
  logic signed [XW-1:0]  in_z;
  logic signed [XW-1:0]  in_e;
  logic signed [CHW-1:0] in_ch;

  assign in_x  = $signed(in_tdata[XW-1:0]);
  assign in_y  = $signed(in_tdata[2*XW-1:XW]);
  assign in_z  = $signed(in_tdata[3*XW-1:2*XW]);
  assign in_e  = $signed(in_tdata[4*XW-1:3*XW]);
  assign in_ch = $signed(in_tdata[4*XW+CHW-1:4*XW]);

  // stage 1: the four rotation products
  logic signed [ROTPW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [XW-1:0]    x1_r, y1_r, z1_r, e1_r;
  logic signed [CHW-1:0]   ch1_r;
  rot_dir_t                dir1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxc_r  <= in_x * COS_Q16;
      pys_r  <= in_y * SIN_Q16;
      pxs_r  <= in_x * SIN_Q16;
      pyc_r  <= in_y * COS_Q16;
      x1_r   <= in_x;
      y1_r   <= in_y;
      z1_r   <= in_z;
      e1_r   <= in_e;
      ch1_r  <= in_ch;
      dir1_r <= rot_dir_t'(in_tuser);
    end
  end

  // stage 2: sum, round and pick by direction; code three acts as no rotation
  logic signed [RXW-1:0] rx_s2, ry_s2;
  logic signed [RXW-1:0] rx2_r, ry2_r;
  logic signed [XW-1:0]  x2_r, y2_r, z2_r, e2_r;
  logic signed [CHW-1:0] ch2_r;

  always_comb begin
    case (dir1_r)
      DIR_POS: begin
        rx_s2 = rnd16(ROTSW'(pxc_r) - ROTSW'(pys_r));
        ry_s2 = rnd16(ROTSW'(pxs_r) + ROTSW'(pyc_r));
      end
      DIR_NEG: begin
        rx_s2 = rnd16(ROTSW'(pxc_r) + ROTSW'(pys_r));
        ry_s2 = rnd16(ROTSW'(pyc_r) - ROTSW'(pxs_r));
      end
      default: begin
        rx_s2 = RXW'(x1_r);
        ry_s2 = RXW'(y1_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx2_r <= rx_s2;
      ry2_r <= ry_s2;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      e2_r  <= e1_r;
      ch2_r <= ch1_r;
    end
  end

  // stage 3: squares and the zero test
  logic signed [SQW-1:0] sqx3_r, sqy3_r;
  sb_sqrt_t              sb3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx3_r     <= rx2_r * rx2_r;
      sqy3_r     <= ry2_r * ry2_r;
      sb3_r.x    <= x2_r;
      sb3_r.y    <= y2_r;
      sb3_r.z    <= z2_r;
      sb3_r.e    <= e2_r;
      sb3_r.ch   <= ch2_r;
      sb3_r.rx   <= rx2_r;
      sb3_r.ry   <= ry2_r;
      sb3_r.zero <= (rx2_r == '0) && (ry2_r == '0);
    end
  end

  // stage 4: radicand, squared length scaled by 2^16
  logic [VW-1:0] rad4_r;
  sb_sqrt_t      sb4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rad4_r <= (VW'($unsigned(sqx3_r)) + VW'($unsigned(sqy3_r))) << 16;
      sb4_r  <= sb3_r;
    end
  end

  // square root: length in 1/65536 mm
  logic [LW-1:0] len_s;

  pje_isqrt #(
    .OW (LW)
  ) u_isqrt (
    .clk      (clk),
    .en       (adv),
    .v_in     (rad4_r),
    .root_out (len_s)
  );

  sb_sqrt_t sbq_r [LW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sbq_r[0] <= sb4_r;
      for (int k = 1; k < LW; k++) begin
        sbq_r[k] <= sbq_r[k-1];
      end
    end
  end

  // stage 5: numerator and scaled coordinates
  logic signed [NW-1:0] num_s5;
  logic signed [PW-1:0] prx5_r, pry5_r;
  logic [LW-1:0]        len5_r;
  sb_div_t              sb5_r;

  assign num_s5 = $signed({{(NW-LW){1'b0}}, len_s}) + ($signed(NW'(sbq_r[LW-1].ch)) <<< 8);

  always_ff @(posedge clk) begin
    if (adv) begin
      prx5_r      <= sbq_r[LW-1].rx * num_s5;
      pry5_r      <= sbq_r[LW-1].ry * num_s5;
      len5_r      <= len_s;
      sb5_r.x     <= sbq_r[LW-1].x;
      sb5_r.y     <= sbq_r[LW-1].y;
      sb5_r.z     <= sbq_r[LW-1].z;
      sb5_r.e     <= sbq_r[LW-1].e;
      sb5_r.zero  <= sbq_r[LW-1].zero;
      sb5_r.neg_x <= 1'b0;
      sb5_r.neg_y <= 1'b0;
    end
  end

  // stage 6: magnitudes plus half the divisor for rounding
  logic [PW-1:0] magx_s6, magy_s6;
  logic [DW-1:0] dvx6_r, dvy6_r;
  logic [LW-1:0] len6_r;
  sb_div_t       sb6_r;

  assign magx_s6 = prx5_r[PW-1] ? PW'(0) - $unsigned(prx5_r) : $unsigned(prx5_r);
  assign magy_s6 = pry5_r[PW-1] ? PW'(0) - $unsigned(pry5_r) : $unsigned(pry5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dvx6_r      <= DW'(magx_s6) + DW'(len5_r >> 1);
      dvy6_r      <= DW'(magy_s6) + DW'(len5_r >> 1);
      len6_r      <= len5_r;
      sb6_r.x     <= sb5_r.x;
      sb6_r.y     <= sb5_r.y;
      sb6_r.z     <= sb5_r.z;
      sb6_r.e     <= sb5_r.e;
      sb6_r.zero  <= sb5_r.zero;
      sb6_r.neg_x <= prx5_r[PW-1];
      sb6_r.neg_y <= pry5_r[PW-1];
    end
  end

  // dividers, one each for x and y
  logic [QW-1:0] qx_s, qy_s;

  pje_div #(
    .DW (DW),
    .LW (LW),
    .QW (QW)
  ) u_div_x (
    .clk     (clk),
    .en      (adv),
    .num_in  (dvx6_r),
    .den_in  (len6_r),
    .quo_out (qx_s)
  );

  pje_div #(
    .DW (DW),
    .LW (LW),
    .QW (QW)
  ) u_div_y (
    .clk     (clk),
    .en      (adv),
    .num_in  (dvy6_r),
    .den_in  (len6_r),
    .quo_out (qy_s)
  );

  sb_div_t sbd_r [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sbd_r[0] <= sb6_r;
      for (int k = 1; k < QW; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end
    end
  end

  // output stage: sign, clamp, zero length bypass
  sb_div_t              sbo;
  logic signed [QW:0]   vx_s, vy_s;
  logic signed [XW-1:0] nx_s, ny_s;
  logic                 satx_s, saty_s;
  logic [OUT_DW-1:0]    out_tdata_r;
  logic [OUT_UW-1:0]    out_tuser_r;

  assign sbo  = sbd_r[QW-1];
  assign vx_s = sbo.neg_x ? -$signed({1'b0, qx_s}) : $signed({1'b0, qx_s});
  assign vy_s = sbo.neg_y ? -$signed({1'b0, qy_s}) : $signed({1'b0, qy_s});

  always_comb begin
    satx_s = 1'b0;
    saty_s = 1'b0;
    if (vx_s > (QW+1)'(COORD_MAX)) begin
      nx_s   = COORD_MAX;
      satx_s = 1'b1;
    end else if (vx_s < (QW+1)'(COORD_MIN)) begin
      nx_s   = COORD_MIN;
      satx_s = 1'b1;
    end else begin
      nx_s = XW'(vx_s);
    end
    if (vy_s > (QW+1)'(COORD_MAX)) begin
      ny_s   = COORD_MAX;
      saty_s = 1'b1;
    end else if (vy_s < (QW+1)'(COORD_MIN)) begin
      ny_s   = COORD_MIN;
      saty_s = 1'b1;
    end else begin
      ny_s = XW'(vy_s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sbo.zero) begin
        out_tdata_r <= {(OUT_DW-4*XW)'(0), sbo.e, sbo.z, sbo.y, sbo.x};
        out_tuser_r <= {1'b0, 1'b1};
      end else begin
        out_tdata_r <= {(OUT_DW-4*XW)'(0), sbo.e, sbo.z, ny_s, nx_s};
        out_tuser_r <= {satx_s || saty_s, 1'b0};
      end
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ----- design/pje_checker.sv -----
// pje_checker: port-level assertions for planar_jog_rotate_and_extend
// depends on pje_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module pje_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [pje_pkg::IN_DW-1:0]  in_tdata,
  input logic [pje_pkg::IN_UW-1:0]  in_tuser,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [pje_pkg::OUT_DW-1:0] out_tdata,
  input logic [pje_pkg::OUT_UW-1:0] out_tuser
);

  import pje_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // input side moves exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // zero length never reports a clamp
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("zero length beat flagged saturated");

  // a clamp leaves x or y at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata[XW-1:0] == COORD_MIN) || (out_tdata[XW-1:0] == COORD_MAX) ||
      (out_tdata[2*XW-1:XW] == COORD_MIN) || (out_tdata[2*XW-1:XW] == COORD_MAX))
    else $error("saturated beat without a clamped coordinate");

  // pipeline is empty after reset
  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind planar_jog_rotate_and_extend pje_checker u_pje_checker (.*);

// ----- verif/tb.sv -----
// tb: self-checking bench for planar_jog_rotate_and_extend, random and directed jogs
// depends on pje_pkg and the planar_jog_rotate_and_extend rtl
`timescale 1ns / 1ps

module tb;
  import pje_pkg::*;

  typedef struct {
    logic [18:0] x, y, z, e;
    logic [1:0]  dir;
    logic [16:0] ch;
  } jog_t;

  typedef struct {
    logic [18:0] x, y, z, e;
    logic        zero, sat;
  } pos_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [IN_UW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic [OUT_UW-1:0] out_tuser;

  jog_t jog_q[$];      // jogs waiting for the driver
  pos_t want_q[$];     // predicted positions, oldest first
  int   mismatches = 0;
  bit   stim_done = 0;
  bit   hold_off = 0;  // sender pause until the pipe drains
  bit   calm = 0;      // stretch with no idling on either side

  always #6 clk = ~clk;

  planar_jog_rotate_and_extend uut (.*);

  function automatic longint rdiv(longint n, longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m + d / 2) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp(longint v, ref bit sat);
    if (v < -262144) begin
      sat = 1;
      return -262144;
    end
    if (v > 262143) begin
      sat = 1;
      return 262143;
    end
    return v;
  endfunction

  // rotate one step, then stretch the planar radius by the change
  function automatic pos_t jog_position(jog_t j);
    pos_t p;
    longint x, y, ch, rx, ry, len, num, nx, ny;
    longint c, s;
    bit sat;
    x = longint'($signed(j.x));
    y = longint'($signed(j.y));
    ch = longint'($signed(j.ch));
    c = 65523;
    s = 1147;
    sat = 0;
    if (j.dir == DIR_POS) begin
      rx = rdiv(x * c - y * s, 65536);
      ry = rdiv(x * s + y * c, 65536);
    end else if (j.dir == DIR_NEG) begin
      rx = rdiv(x * c + y * s, 65536);
      ry = rdiv(-x * s + y * c, 65536);
    end else begin
      rx = x;
      ry = y;
    end
    p.z = j.z;
    p.e = j.e;
    if (rx == 0 && ry == 0) begin
      p.x = j.x;
      p.y = j.y;
      p.zero = 1;
      p.sat = 0;
    end else begin
      len = isqrt(longint'(rx * rx + ry * ry) << 16);
      num = len + ch * 256;
      nx = clamp(rdiv(rx * num, len), sat);
      ny = clamp(rdiv(ry * num, len), sat);
      p.x = nx[18:0];
      p.y = ny[18:0];
      p.zero = 0;
      p.sat = sat;
    end
    return p;
  endfunction

  function automatic logic [18:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 19'h3ffff;
      1: return 19'h40000;
      2: return 19'($urandom_range(0, 40) - 20);
      3: return 19'($urandom_range(0, 4000) - 2000);
      default: return 19'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_change();
    case ($urandom_range(0, 4))
      0: return 17'h0ffff;
      1: return 17'h10000;
      2: return 17'($urandom_range(0, 200) - 100);
      default: return 17'($urandom);
    endcase
  endfunction

  task automatic add_jog(logic [18:0] x, logic [18:0] y, logic [1:0] d, logic [16:0] ch);
    jog_t j;
    j.x = x;
    j.y = y;
    j.z = rand_coord();
    j.e = rand_coord();
    j.dir = d;
    j.ch = ch;
    jog_q.push_back(j);
  endtask

  // driver: when the current beat is taken or none is up, pops the next jog unless held off or idling at random
  always @(posedge clk) begin
    jog_t j;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (jog_q.size() != 0 && !hold_off && (calm || $urandom_range(0, 99) >= 6)) begin
          j = jog_q.pop_front();
          in_tdata <= {3'b0, j.ch, j.e, j.z, j.y, j.x};
          in_tuser <= j.dir;
          in_tvalid <= 1;
          want_q.push_back(jog_position(j));
        end else begin
          in_tvalid <= 0;
        end
      end
      out_tready <= calm || $urandom_range(0, 99) >= 6;
    end
  end

  // monitor: checks every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    pos_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        w = want_q.pop_front();
        if (out_tdata[18:0] !== w.x || out_tdata[37:19] !== w.y ||
            out_tdata[56:38] !== w.z || out_tdata[75:57] !== w.e ||
            out_tuser[0] !== w.zero || out_tuser[1] !== w.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x %h y %h z %h e %h zl %b sat %b, got %h / %b",
                     w.x, w.y, w.z, w.e, w.zero, w.sat, out_tdata[75:0], out_tuser);
        end
      end
    end
  end

  initial begin
    logic [18:0] ext[4];
    ext = '{19'h3ffff, 19'h40000, 19'h0, 19'h1};
    // extremes, every direction including code three, zero length, mirroring
    foreach (ext[i]) add_jog(ext[i], ext[(i + 1) % 4], DIR_POS, 17'h0ffff);
    foreach (ext[i]) add_jog(ext[i], ext[i], DIR_NEG, 17'h10000);
    add_jog(0, 0, DIR_NONE, 17'h00100);
    add_jog(0, 0, DIR_POS, 17'h0ffff);
    add_jog(1, 0, DIR_POS, 0);           // rotation rounds back to (1, 0)
    add_jog(0, 1, DIR_NEG, 0);
    add_jog(19'd1000, 19'd500, 2'd3, 17'd10);
    add_jog(19'd1000, 19'h7fc18, DIR_NONE, 17'h1fff0);  // shrink the radius by 16
    add_jog(19'd256, 19'd0, DIR_POS, 17'h1ffff);
    add_jog(19'h3ffff, 19'h3ffff, DIR_NONE, 17'h0ffff); // clamps
    add_jog(19'h40000, 19'h40000, DIR_NEG, 0);
    repeat (6) @(posedge clk);
    rst_n <= 1;
    wait (jog_q.size() == 0 && want_q.size() == 0);
    repeat (5) @(posedge clk);
    for (int i = 0; i < 950; i++) begin
      if (i == 300) begin
        // hold the sender until the pipe has drained
        hold_off <= 1;
        wait (want_q.size() == 0);
        @(posedge clk);
        hold_off <= 0;
      end
      if (i == 500) calm <= 1;
      if (i == 700) calm <= 0;
      add_jog(rand_coord(), rand_coord(), 2'($urandom_range(0, 3)), rand_change());
      if (jog_q.size() > 20) wait (jog_q.size() < 10);
    end
    wait (jog_q.size() == 0 && !in_tvalid);
    wait (want_q.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pje_pkg.sv
design/pje_isqrt.sv
design/pje_div.sv
design/planar_jog_rotate_and_extend.sv
design/pje_checker.sv
verif/tb.sv
